>>> hdl/utcmjd_pkg.sv
// Shared types and constants for the UTC to MJD and sidereal time pipeline.
// No dependencies.
package utcmjd_pkg;

  localparam int DAY_W = 22;
  localparam int MAG_W = 24;
  localparam int SOD_W = 17;

  localparam int CAL_LAT  = 6;
  localparam int MUL_LAT  = 2;
  localparam int CDIV_LAT = 6;
  localparam int TAIL_LAT = 4;

  // floor((153*m + 2)/5) with the March-based month m, indexed by month_index
  localparam logic [8:0] MONTH_OFS [16] = '{
    9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367, 9'd398
  };

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [SOD_W-1:0] sod;
  } cal_out_t;

endpackage

>>> hdl/utcmjd_mul.sv
// Pipelined unsigned multiplier, split into 32x32 partial products.
// Two register stages; keeps the low PW bits of the product. No dependencies.
module utcmjd_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int PW = 64
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [PW-1:0] p
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int SW = (NA + NB) * 32;

  logic [NA*32-1:0] ap;
  logic [NB*32-1:0] bp;
  logic [63:0]      pp [NA*NB];
  logic [SW-1:0]    acc;

  assign ap = (NA*32)'(a);
  assign bp = (NB*32)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i*NB+j] <= 64'(ap[i*32 +: 32]) * 64'(bp[j*32 +: 32]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp[i*NB+j]) << (32*(i+j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc[PW-1:0];
    end
  end

endmodule

>>> hdl/utcmjd_dly.sv
// Enabled shift line of N stages for aligning side data in the pipeline.
// No dependencies.
module utcmjd_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < N; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

>>> hdl/utcmjd_cdiv.sv
// Exact floor(x * PNUM / DDEN) mod 2^FRAC_BITS for constant PNUM, DDEN.
// Reciprocal estimate plus a one-step remainder fix. Uses utcmjd_mul, utcmjd_dly.
module utcmjd_cdiv #(
  parameter int           FRAC_BITS = 32,
  parameter int           XW        = 24,
  parameter logic [255:0] PNUM      = 256'd1,
  parameter logic [255:0] DDEN      = 256'd3
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [XW-1:0]        x,
  output logic [FRAC_BITS-1:0] y
);

  localparam logic [255:0] QV = PNUM / DDEN;
  localparam logic [255:0] RV = PNUM % DDEN;
  localparam logic [255:0] GV = (RV << XW) / DDEN;
  localparam int KW = $clog2(DDEN) + 1;
  localparam int GW = (GV == 256'd0) ? 1 : $clog2(GV + 256'd1);

  localparam logic [FRAC_BITS-1:0] QF = QV[FRAC_BITS-1:0];
  localparam logic [KW-1:0]        RK = RV[KW-1:0];
  localparam logic [KW-1:0]        DK = DDEN[KW-1:0];
  localparam logic [GW-1:0]        GK = GV[GW-1:0];

  logic [FRAC_BITS-1:0] plo, plo_d;
  logic [KW-1:0]        pr, pr_d, qd;
  logic [XW+GW-1:0]     pg;
  logic [GW-1:0]        qe, qe_d;
  logic                 inc;
  logic [FRAC_BITS-1:0] plo5;
  logic [GW-1:0]        qe5;

  utcmjd_mul #(.AW(XW), .BW(FRAC_BITS), .PW(FRAC_BITS)) u_q (
    .clk(clk), .en(en), .a(x), .b(QF), .p(plo)
  );
  utcmjd_mul #(.AW(XW), .BW(KW), .PW(KW)) u_r (
    .clk(clk), .en(en), .a(x), .b(RK), .p(pr)
  );
  utcmjd_mul #(.AW(XW), .BW(GW), .PW(XW+GW)) u_g (
    .clk(clk), .en(en), .a(x), .b(GK), .p(pg)
  );

  assign qe = pg[XW+GW-1:XW];

  utcmjd_mul #(.AW(GW), .BW(KW), .PW(KW)) u_d (
    .clk(clk), .en(en), .a(qe), .b(DK), .p(qd)
  );

  utcmjd_dly #(.W(KW), .N(2)) u_pr_dly (.clk(clk), .en(en), .d(pr), .q(pr_d));
  utcmjd_dly #(.W(FRAC_BITS), .N(2)) u_plo_dly (.clk(clk), .en(en), .d(plo), .q(plo_d));
  utcmjd_dly #(.W(GW), .N(2)) u_qe_dly (.clk(clk), .en(en), .d(qe), .q(qe_d));

  // remainder of the estimate lies in [0, 2D); at D or above the quotient is one short
  always_ff @(posedge clk) begin
    if (en) begin
      inc  <= KW'(pr_d - qd) >= DK;
      plo5 <= plo_d;
      qe5  <= qe_d;
      y    <= plo5 + FRAC_BITS'(qe5) + FRAC_BITS'(inc);
    end
  end

endmodule

>>> hdl/utcmjd_cal.sv
// Calendar front end: seconds of day, MJD day number and |2*MJD - 103089|.
// Six register stages. Uses utcmjd_pkg.
module utcmjd_cal (
  input  logic                 clk,
  input  logic                 en,
  input  logic [13:0]          year,
  input  logic [3:0]           month_index,
  input  logic [4:0]           day_of_month,
  input  logic [4:0]           hour,
  input  logic [5:0]           minute,
  input  logic [5:0]           second,
  output utcmjd_pkg::cal_out_t co
);

  import utcmjd_pkg::*;

  logic [16:0]        sraw, sod2, sod3, sod4, sod5;
  logic [14:0]        v1, v2;
  logic [8:0]         tm1, tm2, tm3, tm4;
  logic               carry2, carry3, carry4;
  logic [7:0]         q2;
  logic signed [8:0]  c3;
  logic [6:0]         yy3;
  logic signed [25:0] pa4;
  logic [17:0]        pb4;
  logic signed [24:0] day5;
  logic signed [25:0] n5;

  // v = y + 100 with y the March-based year, so v stays positive
  always_ff @(posedge clk) begin
    if (en) begin
      sraw <= 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
      v1   <= 15'(year) + 15'd100 - 15'(month_index < 4'd2);
      tm1  <= MONTH_OFS[month_index] + 9'(day_of_month);

      carry2 <= sraw >= 17'd86400;
      sod2   <= (sraw >= 17'd86400) ? sraw - 17'd86400 : sraw;
      q2     <= 8'((29'(v1) * 29'd20972) >> 21);
      v2     <= v1;
      tm2    <= tm1;

      c3     <= signed'(9'(q2) - 9'd1);
      yy3    <= 7'(v2 - 15'(q2) * 15'd100);
      carry3 <= carry2;
      sod3   <= sod2;
      tm3    <= tm2;

      pa4    <= 26'(c3) * 26'sd146097;
      pb4    <= 18'(yy3) * 18'd1461;
      carry4 <= carry3;
      sod4   <= sod3;
      tm4    <= tm3;

      day5 <= 25'(pa4 >>> 2) + 25'(pb4 >> 2) + 25'(tm4) + 25'(carry4) - 25'd678882;
      sod5 <= sod4;

      co.mag <= n5[25] ? MAG_W'(-n5) : MAG_W'(n5);
      co.neg <= n5[25];
      co.day <= day5[DAY_W-1:0];
      co.sod <= sod5;
    end
  end

  assign n5 = (26'(day5) <<< 1) - 26'sd103089;

endmodule

>>> hdl/utc_to_mjd_and_sidereal_time.sv
// Top level: UTC timestamp to MJD, GMST (IAU 1982) and local sidereal time.
// Uses utcmjd_pkg, utcmjd_cal, utcmjd_mul, utcmjd_dly, utcmjd_cdiv.
//
// Takes one timestamp item per clock while the output is not stalled; six
// calendar stages, four for the squared and cubed century term, six for the
// exact constant divisions and four for the sidereal sum and hour/minute
// split. A stalled output freezes the whole pipeline, so nothing is lost.
// longitude_e7 is written through cfg_wr_en/cfg_wr_data; the user must do so
// only with the pipe empty (not enforced); it takes effect on the next item.
module utc_to_mjd_and_sidereal_time #(
  parameter int FRAC_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,   // longitude_e7
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // year, month_index, day_of_month, hour, minute, second
  input  logic [39:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mjd_day, utc_frac, gmst_turns, lst_turns, lst_hrs, lst_minute, zero pad
  output logic [135:0] m_axis_tdata
);

  import utcmjd_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int LAT = CAL_LAT + 2 * MUL_LAT + CDIV_LAT + TAIL_LAT;
  localparam int RS  = (F >= 32) ? F - 32 : 0;
  localparam int LS  = (F < 32) ? 32 - F : 0;
  localparam logic [255:0] T0W = (256'd2411054841 << F) / 256'd8640000000;
  localparam logic [F-1:0] T0  = T0W[F-1:0];

  logic signed [31:0] longitude_e7;
  logic [31:0]        lmag;
  logic               en;
  logic [LAT-1:0]     vld;
  cal_out_t           co;

  logic [MAG_W-1:0]   mag8, mag10;
  logic [2*MAG_W-1:0] mag2, mag2_10;
  logic [3*MAG_W-1:0] mag3;
  logic [SOD_W-1:0]   sod10;
  logic               neg16;
  logic [F-1:0]       t1, t2, t3, tk, frac16, lt16, frac19;
  logic [DAY_W-1:0]   day19;
  logic [F-1:0]       gmst17, lt17, gmst18, lst18, gmst19, lst19;
  logic [F+10:0]      pm;
  logic [F+4:0]       ph;
  logic [10:0]        mins19;
  logic [4:0]         hr19;

  logic [DAY_W-1:0] o_day;
  logic [31:0]      o_frac, o_gmst, o_lst;
  logic [4:0]       o_hr;
  logic [5:0]       o_min;

  function automatic logic [31:0] to32(input logic [F-1:0] f);
    to32 = 32'((64'(f) >> RS) << LS);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      longitude_e7 <= '0;
    end else if (cfg_wr_en) begin
      longitude_e7 <= signed'(cfg_wr_data);
    end
  end

  assign lmag = longitude_e7[31] ? (~longitude_e7 + 32'd1) : longitude_e7;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  utcmjd_cal u_cal (
    .clk(clk), .en(en),
    .year(s_axis_tdata[13:0]), .month_index(s_axis_tdata[17:14]),
    .day_of_month(s_axis_tdata[22:18]), .hour(s_axis_tdata[27:23]),
    .minute(s_axis_tdata[33:28]), .second(s_axis_tdata[39:34]),
    .co(co)
  );

  utcmjd_mul #(.AW(MAG_W), .BW(MAG_W), .PW(2*MAG_W)) u_sq (
    .clk(clk), .en(en), .a(co.mag), .b(co.mag), .p(mag2)
  );
  utcmjd_dly #(.W(MAG_W), .N(2)) u_mag8 (.clk(clk), .en(en), .d(co.mag), .q(mag8));
  utcmjd_mul #(.AW(2*MAG_W), .BW(MAG_W), .PW(3*MAG_W)) u_cube (
    .clk(clk), .en(en), .a(mag2), .b(mag8), .p(mag3)
  );
  utcmjd_dly #(.W(MAG_W), .N(2)) u_mag10 (.clk(clk), .en(en), .d(mag8), .q(mag10));
  utcmjd_dly #(.W(2*MAG_W), .N(2)) u_mag2_10 (.clk(clk), .en(en), .d(mag2), .q(mag2_10));
  utcmjd_dly #(.W(SOD_W), .N(4)) u_sod10 (.clk(clk), .en(en), .d(co.sod), .q(sod10));
  utcmjd_dly #(.W(1), .N(10)) u_neg16 (.clk(clk), .en(en), .d(co.neg), .q(neg16));
  utcmjd_dly #(.W(DAY_W), .N(13)) u_day19 (.clk(clk), .en(en), .d(co.day), .q(day19));

  utcmjd_cdiv #(.FRAC_BITS(F), .XW(MAG_W),
    .PNUM(256'd8640184812866 << (F - 14)),
    .DDEN(256'd27 * 256'd390625 * 256'd36525)) u_t1 (
    .clk(clk), .en(en), .x(mag10), .y(t1)
  );
  utcmjd_cdiv #(.FRAC_BITS(F), .XW(2*MAG_W),
    .PNUM(256'd93104 << (F - 15)),
    .DDEN(256'd27 * 256'd390625 * 256'd36525 * 256'd36525)) u_t2 (
    .clk(clk), .en(en), .x(mag2_10), .y(t2)
  );
  utcmjd_cdiv #(.FRAC_BITS(F), .XW(3*MAG_W),
    .PNUM(256'd62 << (F - 17)),
    .DDEN(256'd27 * 256'd1953125 * 256'd36525 * 256'd36525 * 256'd36525)) u_t3 (
    .clk(clk), .en(en), .x(mag3), .y(t3)
  );
  utcmjd_cdiv #(.FRAC_BITS(F), .XW(SOD_W),
    .PNUM(256'd1002737909350795 << (F - 22)),
    .DDEN(256'd675 * 256'd30517578125)) u_tk (
    .clk(clk), .en(en), .x(sod10), .y(tk)
  );
  utcmjd_cdiv #(.FRAC_BITS(F), .XW(SOD_W),
    .PNUM(256'd1 << (F - 7)), .DDEN(256'd675)) u_frac (
    .clk(clk), .en(en), .x(sod10), .y(frac16)
  );
  utcmjd_cdiv #(.FRAC_BITS(F), .XW(32),
    .PNUM(256'd1 << (F - 10)), .DDEN(256'd3515625)) u_lon (
    .clk(clk), .en(en), .x(lmag), .y(lt16)
  );

  utcmjd_dly #(.W(F), .N(3)) u_frac19 (.clk(clk), .en(en), .d(frac16), .q(frac19));

  assign pm = (F+11)'(lst18) * (F+11)'(1440);
  assign ph = (F+5)'(lst18) * (F+5)'(24);

  always_ff @(posedge clk) begin
    if (en) begin
      gmst17 <= T0 + (neg16 ? F'(-t1) : t1) + t2 - (neg16 ? F'(-t3) : t3) + tk;
      lt17   <= longitude_e7[31] ? F'(-lt16) : lt16;

      lst18  <= gmst17 + lt17;
      gmst18 <= gmst17;

      mins19 <= pm[F+10:F];
      hr19   <= ph[F+4:F];
      lst19  <= lst18;
      gmst19 <= gmst18;

      o_min  <= 6'(mins19 - 11'(hr19) * 11'd60);
      o_hr   <= hr19;
      o_lst  <= to32(lst19);
      o_gmst <= to32(gmst19);
      o_frac <= to32(frac19);
      o_day  <= day19;
    end
  end

  assign m_axis_tdata = {7'd0, o_min, o_hr, o_lst, o_gmst, o_frac, o_day};

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_stall_freezes_valid: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid chain moved during stall");

  a_time_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> o_hr <= 5'd23 && o_min <= 6'd59)
    else $error("sidereal hour or minute out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_axis_tvalid)
    else $error("output valid straight after reset");
`endif

endmodule

>>> tb/utc_mjd_checker.sv
`timescale 1ns / 1ps
// Checker for utc_to_mjd_and_sidereal_time: watches config and both streams,
// predicts MJD, day fraction, GMST and LST per item and compares in order.
// Depends only on the stream and config ports of the block.
module utc_mjd_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [5:0]  lst_minute;
    logic [4:0]  lst_hrs;
    logic [31:0] lst_turns;
    logic [31:0] gmst_turns;
    logic [31:0] utc_frac;
    logic [21:0] mjd_day;
  } sidereal_t;

  logic [31:0] longitude;
  sidereal_t   expected_q[$];

  function automatic longint fdiv(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // floor(num * 2^32 / den) mod 2^32
  function automatic logic [31:0] turns(input logic [255:0] num, input logic [255:0] den);
    logic [255:0] q;
    q = (num << 32) / den;
    return q[31:0];
  endfunction

  function automatic sidereal_t sidereal_time(input logic [39:0] d, input logic [31:0] lon_raw);
    sidereal_t   r;
    longint      yr, mon, mday, secs, carry, m, y, c, yy, day, n, lon;
    logic [255:0] mag, lmag, cent;
    logic [31:0] t0, t1, t2, t3, tk, gmst, lturn, lst;
    logic [63:0] mins;
    yr    = d[13:0];
    mon   = d[17:14];
    mday  = d[22:18];
    secs  = d[27:23] * 3600 + d[33:28] * 60 + d[39:34];
    carry = secs / 86400;
    secs  = secs % 86400;
    if (mon < 2) begin
      m = mon + 10;
      y = yr - 1;
    end else begin
      m = mon - 2;
      y = yr;
    end
    c   = fdiv(y, 100);
    yy  = y - 100 * c;
    day = fdiv(146097 * c, 4) + fdiv(1461 * yy, 4) + fdiv(153 * m + 2, 5)
        + mday - 678882 + carry;
    n    = 2 * day - 103089;
    mag  = (n < 0) ? -n : n;
    cent = 73050;
    t0 = turns(256'd2411054841, 256'd8640000000);
    t1 = turns(256'd8640184812866 * mag, 256'd86400000000 * cent);
    t2 = turns(256'd93104 * mag * mag, 256'd86400000000 * cent * cent);
    t3 = turns(256'd62 * mag * mag * mag, 256'd864000000000 * cent * cent * cent);
    if (n < 0) begin
      t1 = -t1;
      t3 = -t3;
    end
    tk   = turns(256'd1002737909350795 * secs, 256'd86400 * 256'd1000000000000000);
    gmst = t0 + t1 + t2 - t3 + tk;
    lon  = $signed(lon_raw);
    lmag = (lon < 0) ? -lon : lon;
    lturn = turns(lmag, 256'd3600000000);
    if (lon < 0) lturn = -lturn;
    lst  = gmst + lturn;
    mins = ({32'd0, lst} * 64'd1440) >> 32;
    r.mjd_day      = day[21:0];
    r.utc_frac     = turns(secs, 256'd86400);
    r.gmst_turns   = gmst;
    r.lst_turns    = lst;
    r.lst_hrs      = mins / 60;
    r.lst_minute   = mins % 60;
    return r;
  endfunction

  task automatic field_check(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    sidereal_t e, a;
    if (rst) begin
      longitude = 32'd0;
      fail_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(sidereal_time(s_axis_tdata, longitude));
      if (cfg_wr_en) longitude = cfg_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        a = m_axis_tdata[128:0];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item, got %h", $time, a);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          field_check("mjd_day", e.mjd_day, a.mjd_day);
          field_check("utc_frac", e.utc_frac, a.utc_frac);
          field_check("gmst_turns", e.gmst_turns, a.gmst_turns);
          field_check("lst_turns", e.lst_turns, a.lst_turns);
          field_check("lst_hrs", e.lst_hrs, a.lst_hrs);
          field_check("lst_minute", e.lst_minute, a.lst_minute);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> tb/tb_utc_to_mjd_and_sidereal_time.sv
`timescale 1ns / 1ps
// Testbench top: drives timestamps and longitude settings into the block,
// stalls both streams at random and reports the verdict from utc_mjd_checker.
module tb_utc_to_mjd_and_sidereal_time;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [31:0]  cfg_wr_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  int           fail_count;
  int           pending;
  bit           no_gaps = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  utc_to_mjd_and_sidereal_time u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  utc_mjd_checker u_chk (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    int g;
    if (!rst) begin
      g = gap_len();
      if (g == 0) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at a falling edge after the item is taken
  task automatic send(input int yr, input int mon, input int md, input int hh,
                      input int mm, input int ss);
    int  g;
    bit  ok;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {ss[5:0], mm[5:0], hh[4:0], md[4:0], mon[3:0], yr[13:0]};
    do begin
      #1 ok = s_axis_tready;
      @(negedge clk);
    end while (!ok);
  endtask

  task automatic set_longitude(input logic [31:0] v);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (25) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic random_item();
    int yr, mon, md, hh, mm, ss;
    yr  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1859, 9999);
    mon = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
    md  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 31);
    hh  = ($urandom_range(0, 15) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
    mm  = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
    ss  = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
    send(yr, mon, md, hh, mm, ss);
  endtask

  initial begin
    logic [31:0] lons [5];
    lons = '{32'd1800000000, -32'sd1800000000, 32'hFFFFFFFF, 32'd0, 32'd0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    send(1859, 0, 1, 0, 0, 0);
    send(9999, 11, 31, 23, 59, 59);
    send(2000, 0, 1, 12, 0, 0);
    send(1858, 10, 17, 0, 0, 0);
    send(2016, 11, 31, 23, 59, 60);
    send(16383, 15, 31, 31, 63, 63);
    send(0, 0, 0, 0, 0, 0);
    send(1, 1, 1, 0, 0, 0);
    send(2024, 12, 1, 6, 30, 0);
    send(2024, 13, 5, 6, 30, 0);
    send(2024, 14, 0, 6, 30, 0);
    send(2024, 15, 9, 24, 0, 0);
    send(1900, 1, 28, 23, 60, 0);
    for (int mo = 0; mo < 12; mo++) send(1987 + mo, mo, 10 + mo, mo, mo * 5, mo * 4);

    // random phases across longitude settings
    for (int ph = 0; ph < 6; ph++) begin
      set_longitude((ph < 3) ? lons[ph] : $urandom_range(0, 3600000000) - 32'd1800000000);
      no_gaps = (ph == 2);
      for (int i = 0; i < 175; i++) random_item();
    end
    no_gaps = 1'b0;
    s_axis_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("PASS utc_to_mjd_and_sidereal_time");
    else
      $display("FAIL utc_to_mjd_and_sidereal_time");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL utc_to_mjd_and_sidereal_time");
    $finish;
  end

endmodule

>>> filelist.f
hdl/utcmjd_pkg.sv
hdl/utcmjd_mul.sv
hdl/utcmjd_dly.sv
hdl/utcmjd_cdiv.sv
hdl/utcmjd_cal.sv
hdl/utc_to_mjd_and_sidereal_time.sv
tb/utc_mjd_checker.sv
tb/tb_utc_to_mjd_and_sidereal_time.sv
